// ===== design/sdspi_pkg.sv =====
// Shared types, codes and constants for the SD SPI command transaction engine.
`timescale 1ns / 1ps

package sdspi_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF = 512;
  localparam int unsigned BLOCK_LEN_W         = 10;
  localparam int unsigned QUEUE_DEPTH         = 2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  FILLER        = 8'hFF;
  localparam logic [7:0]  START_TOKEN   = 8'hFE;

  // Input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Reply kinds
  localparam logic [1:0] KIND_R1   = 2'd0;
  localparam logic [1:0] KIND_R3   = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Transaction outcomes
  localparam logic [1:0] OUT_DONE          = 2'd0;
  localparam logic [1:0] OUT_R1_TIMEOUT    = 2'd1;
  localparam logic [1:0] OUT_TOKEN_TIMEOUT = 2'd2;
  localparam logic [1:0] OUT_R1_ABORT      = 2'd3;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [47:0]            frame;
    logic [1:0]             kind;
    logic [BLOCK_LEN_W-1:0] length;
    logic [7:0]             rx;
  } entry_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        chip_select_n;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [1:0]  outcome;
    logic [7:0]  response_byte;
    logic [31:0] r3_value;
  } result_t;

endpackage

// ===== design/sd_spi_command_transaction.sv =====
// Top level of the SD card SPI-mode command transaction engine.
`timescale 1ns / 1ps
// A word that has a result goes through the queue slot, written when the word is accepted,
// and then the result register, written when the sequencer retires the word.
// Throughput: one word per cycle; the sequencer retires one queue word each cycle
// while the result register is free or being taken.
// Reset (rst_n low, synchronous): queue empty, sequencer idle, timeout back to 1000.

module sd_spi_command_transaction #(
  parameter int unsigned MAX_BLOCK_BYTES = sdspi_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [15:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [7:0]                        in_cmd_byte,
  input  logic [31:0]                       in_argument,
  input  logic [7:0]                        in_crc_byte,
  input  logic [1:0]                        in_reply_kind,
  input  logic [sdspi_pkg::BLOCK_LEN_W-1:0] in_block_length,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_tx_valid,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_chip_select_n,
  output logic                              out_data_valid,
  output logic [7:0]                        out_data_byte,
  output logic                              out_done_res,
  output logic [1:0]                        out_outcome,
  output logic [7:0]                        out_response_byte,
  output logic [31:0]                       out_r3_value
);

  logic               q_full;
  logic               push;
  logic               pop;
  sdspi_pkg::entry_t  push_entry;
  sdspi_pkg::q_head_t head;
  sdspi_pkg::result_t result;

  sdspi_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_cmd_byte    (in_cmd_byte),
    .in_argument    (in_argument),
    .in_crc_byte    (in_crc_byte),
    .in_reply_kind  (in_reply_kind),
    .in_block_length(in_block_length),
    .in_rx_byte     (in_rx_byte),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  sdspi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  sdspi_back #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result   (result)
  );

  assign out_tx_valid      = result.tx_valid;
  assign out_tx_byte       = result.tx_byte;
  assign out_chip_select_n = result.chip_select_n;
  assign out_data_valid    = result.data_valid;
  assign out_data_byte     = result.data_byte;
  assign out_done_res      = result.done_res;
  assign out_outcome       = result.outcome;
  assign out_response_byte = result.response_byte;
  assign out_r3_value      = result.r3_value;

endmodule

// ===== design/sdspi_front.sv =====
// Front end: classifies input words into queue entries.
`timescale 1ns / 1ps

module sdspi_front #(
  parameter int unsigned MAX_BLOCK_BYTES = sdspi_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_command,
  input  logic [7:0]                         in_cmd_byte,
  input  logic [31:0]                        in_argument,
  input  logic [7:0]                         in_crc_byte,
  input  logic [1:0]                         in_reply_kind,
  input  logic [sdspi_pkg::BLOCK_LEN_W-1:0]  in_block_length,
  input  logic [7:0]                         in_rx_byte,
  input  logic                               q_full,
  output logic                               push,
  output sdspi_pkg::entry_t                  push_entry
);

  logic len_sat;
  logic known_cmd;

  assign in_ready = !q_full;

  // Unused command codes are taken and dropped here
  assign known_cmd = (in_command == sdspi_pkg::CMD_START) ||
                     (in_command == sdspi_pkg::CMD_BYTE)  ||
                     (in_command == sdspi_pkg::CMD_TICK);
  assign push = in_valid && in_ready && known_cmd;

  assign len_sat = 32'(in_block_length) > MAX_BLOCK_BYTES;

  always_comb begin
    push_entry.frame = {in_cmd_byte, in_argument, in_crc_byte};
    push_entry.rx    = in_rx_byte;
    // Reply kind 3 behaves as R1 only
    push_entry.kind  = (in_reply_kind == sdspi_pkg::KIND_DATA) ? sdspi_pkg::KIND_DATA :
                       (in_reply_kind == sdspi_pkg::KIND_R3)   ? sdspi_pkg::KIND_R3 :
                                                                 sdspi_pkg::KIND_R1;
    push_entry.length = len_sat ? sdspi_pkg::BLOCK_LEN_W'(MAX_BLOCK_BYTES) : in_block_length;
    case (in_command)
      sdspi_pkg::CMD_START: push_entry.op = sdspi_pkg::OP_START;
      sdspi_pkg::CMD_BYTE:  push_entry.op = sdspi_pkg::OP_BYTE;
      default:              push_entry.op = sdspi_pkg::OP_TICK;
    endcase
  end

endmodule

// ===== design/sdspi_queue.sv =====
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module sdspi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sdspi_pkg::entry_t   push_entry,
  output logic                full,
  input  logic                pop,
  output sdspi_pkg::q_head_t  head
);

  localparam int unsigned PTR_W = $clog2(sdspi_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sdspi_pkg::QUEUE_DEPTH + 1);

  sdspi_pkg::entry_t slots_r [sdspi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(sdspi_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(sdspi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(sdspi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/sdspi_back.sv =====
// Back end: transaction sequencer, timeout register and result register.
`timescale 1ns / 1ps

module sdspi_back #(
  parameter int unsigned MAX_BLOCK_BYTES = sdspi_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  sdspi_pkg::q_head_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sdspi_pkg::result_t  result
);

  localparam int unsigned LEN_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned CNT_W = (LEN_W > 3) ? LEN_W : 3;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_SEND  = 7'b0000010,
    PH_R1    = 7'b0000100,
    PH_R3    = 7'b0001000,
    PH_TOKEN = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_CRC   = 7'b1000000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         frame_index_r, frame_index_nxt;
  logic [CNT_W-1:0]   byte_count_r, byte_count_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [47:0]        frame_r, frame_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [CNT_W-1:0]   length_r, length_nxt;
  logic [7:0]         r1_r, r1_nxt;
  logic [31:0]        r3_r, r3_nxt;
  logic [15:0]        timeout_r;
  logic               out_valid_r, out_valid_nxt;
  sdspi_pkg::result_t result_r;
  sdspi_pkg::result_t res_nxt;
  logic               res_vld;
  logic               finish;
  logic [1:0]         fin_outcome;
  logic               expired;
  logic [2:0]         fi_inc;
  logic [CNT_W-1:0]   bc_inc;
  sdspi_pkg::entry_t  e;

  function automatic logic [7:0] pick_byte(input logic [47:0] frame, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = frame[47:40];
      3'd1:    b = frame[39:32];
      3'd2:    b = frame[31:24];
      3'd3:    b = frame[23:16];
      3'd4:    b = frame[15:8];
      default: b = frame[7:0];
    endcase
    return b;
  endfunction

  assign cfg_ready = 1'b1;
  assign e         = head.entry;
  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign expired   = elapsed_r >= timeout_r;
  assign fi_inc    = frame_index_r + 1'b1;
  assign bc_inc    = byte_count_r + 1'b1;
  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Sequencer: one queue word per cycle while the result register is free or being taken
  always_comb begin
    phase_nxt       = phase_r;
    frame_index_nxt = frame_index_r;
    byte_count_nxt  = byte_count_r;
    elapsed_nxt     = elapsed_r;
    frame_nxt       = frame_r;
    kind_nxt        = kind_r;
    length_nxt      = length_r;
    r1_nxt          = r1_r;
    r3_nxt          = r3_r;
    res_vld         = 1'b0;
    finish          = 1'b0;
    fin_outcome     = sdspi_pkg::OUT_DONE;
    res_nxt         = '0;
    res_nxt.tx_valid = 1'b1;
    res_nxt.tx_byte  = sdspi_pkg::FILLER;

    if (pop) begin
      case (e.op)
        sdspi_pkg::OP_START: begin
          if (phase_r == PH_IDLE) begin
            frame_nxt       = e.frame;
            kind_nxt        = e.kind;
            length_nxt      = CNT_W'(e.length);
            frame_index_nxt = '0;
            byte_count_nxt  = '0;
            elapsed_nxt     = '0;
            r1_nxt          = '0;
            r3_nxt          = '0;
            phase_nxt       = PH_SEND;
            res_vld         = 1'b1;
            res_nxt.tx_byte = e.frame[47:40];
          end
        end
        sdspi_pkg::OP_TICK: begin
          if (phase_r != PH_IDLE && elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
        end
        default: begin
          case (phase_r)
            PH_SEND: begin
              res_vld         = 1'b1;
              frame_index_nxt = fi_inc;
              if (fi_inc < 3'd6) begin
                res_nxt.tx_byte = pick_byte(frame_r, fi_inc);
              end else begin
                phase_nxt = PH_R1;
              end
            end
            PH_R1: begin
              res_vld = 1'b1;
              if (!e.rx[7] || expired) begin
                r1_nxt = e.rx;
                if (kind_r == sdspi_pkg::KIND_R3) begin
                  phase_nxt      = PH_R3;
                  byte_count_nxt = '0;
                  r3_nxt         = '0;
                end else if (kind_r == sdspi_pkg::KIND_DATA) begin
                  if (e.rx != 8'h00) begin
                    finish      = 1'b1;
                    fin_outcome = e.rx[7] ? sdspi_pkg::OUT_R1_TIMEOUT
                                          : sdspi_pkg::OUT_R1_ABORT;
                  end else begin
                    phase_nxt   = PH_TOKEN;
                    elapsed_nxt = '0;
                  end
                end else begin
                  finish      = 1'b1;
                  fin_outcome = e.rx[7] ? sdspi_pkg::OUT_R1_TIMEOUT : sdspi_pkg::OUT_DONE;
                end
              end
            end
            PH_R3: begin
              res_vld        = 1'b1;
              r3_nxt         = {r3_r[23:0], e.rx};
              byte_count_nxt = bc_inc;
              if (bc_inc >= CNT_W'(4)) begin
                finish      = 1'b1;
                fin_outcome = r1_r[7] ? sdspi_pkg::OUT_R1_TIMEOUT : sdspi_pkg::OUT_DONE;
              end
            end
            PH_TOKEN: begin
              res_vld = 1'b1;
              if (e.rx == sdspi_pkg::START_TOKEN) begin
                byte_count_nxt = '0;
                phase_nxt      = (length_r == '0) ? PH_CRC : PH_DATA;
              end else if (expired) begin
                finish      = 1'b1;
                fin_outcome = sdspi_pkg::OUT_TOKEN_TIMEOUT;
              end
            end
            PH_DATA: begin
              res_vld            = 1'b1;
              res_nxt.data_valid = 1'b1;
              res_nxt.data_byte  = e.rx;
              byte_count_nxt     = bc_inc;
              if (bc_inc >= length_r) begin
                phase_nxt      = PH_CRC;
                byte_count_nxt = '0;
              end
            end
            PH_CRC: begin
              res_vld        = 1'b1;
              byte_count_nxt = bc_inc;
              if (bc_inc >= CNT_W'(2)) begin
                finish      = 1'b1;
                fin_outcome = sdspi_pkg::OUT_DONE;
              end
            end
            default: begin
              res_vld = 1'b0;
            end
          endcase
        end
      endcase
    end

    // Ending word: release chip select and report status
    if (finish) begin
      phase_nxt             = PH_IDLE;
      res_nxt               = '0;
      res_nxt.chip_select_n = 1'b1;
      res_nxt.done_res      = 1'b1;
      res_nxt.outcome       = fin_outcome;
      res_nxt.response_byte = r1_nxt;
      res_nxt.r3_value      = (kind_r == sdspi_pkg::KIND_R3) ? r3_nxt : 32'h0;
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = res_vld;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      frame_index_r <= '0;
      byte_count_r  <= '0;
      elapsed_r     <= '0;
      frame_r       <= '0;
      kind_r        <= '0;
      length_r      <= '0;
      r1_r          <= '0;
      r3_r          <= '0;
      timeout_r     <= sdspi_pkg::TIMEOUT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      frame_index_r <= frame_index_nxt;
      byte_count_r  <= byte_count_nxt;
      elapsed_r     <= elapsed_nxt;
      frame_r       <= frame_nxt;
      kind_r        <= kind_nxt;
      length_r      <= length_nxt;
      r1_r          <= r1_nxt;
      r3_r          <= r3_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && res_vld) begin
      result_r <= res_nxt;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res_vld && res_nxt.done_res) |=> (phase_r == PH_IDLE))
    else $error("transaction end did not return to idle");

  a_data_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res_vld && res_nxt.data_valid) |-> (phase_r == PH_DATA))
    else $error("block byte reported outside data phase");

  a_frame_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEND) |-> (frame_index_r < 3'd6))
    else $error("frame index beyond command frame");

  a_tx_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (result_r.tx_valid != result_r.done_res))
    else $error("result both exchanges and ends, or neither");

endmodule
